@@ hdl/itrd_pkg.sv @@
`default_nettype none

package itrd_pkg;

   // default sizing
   localparam int DIGIT_SLOTS_DEF = 32;
   localparam int VALUE_BITS_DEF  = 31;

   // field widths
   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   // radix limits and reset value
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   // character mapping
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(8'h41);
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

   // controller to datapath commands
   typedef struct packed {
      logic load;        // take the input value, restart digit count
      logic div_step;    // one restoring division bit
      logic div_last;    // final bit of a digit: store remainder
      logic rd_en;       // read the digit store at the emit index
      logic next_digit;  // current digit taken, step the emit index
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic q_next_zero; // quotient after this step is zero
      logic idx_zero;    // emit index points at the least significant digit
   } status_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] c;
      c = r;
      if (r < RADIX_MIN) c = RADIX_MIN;
      if (r > RADIX_MAX) c = RADIX_MAX;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_DIGITS) c = ASCII_ZERO + CHAR_W'(d);
      else                c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/itrd_channels.sv @@
`default_nettype none

// input channel: one integer per transaction
interface itrd_req_if #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// result channel: one character per transaction
interface itrd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [itrd_pkg::CHAR_W-1:0] digit_char;
   logic                        last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/itrd_ctrl.sv @@
`default_nettype none

module itrd_ctrl #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output itrd_pkg::cmd_type         cmd,
   input  wire itrd_pkg::status_type stat
);

   localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_SHOW = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [BW-1:0] bit_cnt_ff, bit_cnt_in;
   logic          last_bit;

   assign last_bit = (bit_cnt_ff == '0);

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);

   // commands
   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.div_last   = (state_ff == ST_DIV) && last_bit;
      cmd.rd_en      = (state_ff == ST_READ);
      cmd.next_digit = (state_ff == ST_SHOW) && rsp_ready;
   end

   // next state and bit counter
   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in   = ST_DIV;
               bit_cnt_in = BW'(VALUE_BITS - 1);
            end
         end
         ST_DIV: begin
            if (last_bit) begin
               bit_cnt_in = BW'(VALUE_BITS - 1);
               if (stat.q_next_zero) state_in = ST_READ;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) state_in = stat.idx_zero ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/itrd_dp.sv @@
`default_nettype none

module itrd_dp #(
   parameter int DIGIT_SLOTS = itrd_pkg::DIGIT_SLOTS_DEF,
   parameter int VALUE_BITS  = itrd_pkg::VALUE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [itrd_pkg::RADIX_W-1:0]  csr_wr_data,
   input  wire logic [VALUE_BITS-1:0]         req_value,
   input  wire itrd_pkg::cmd_type             cmd,
   output itrd_pkg::status_type               stat,
   output logic [itrd_pkg::CHAR_W-1:0]        rsp_digit_char,
   output logic                               rsp_last
);

   localparam int AW    = $clog2(DIGIT_SLOTS);
   localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
   localparam int RW    = itrd_pkg::RADIX_W;
   localparam int DW    = itrd_pkg::DIGIT_W;

   logic [RW-1:0]         radix_ff;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]      n_ff;
   logic [AW-1:0]         idx_ff;
   logic [DW-1:0]         rd_data_ff;
   logic [DW:0]           trial;
   logic                  ge;
   logic                  store_en;

   logic [DW-1:0] digit_mem [DIGIT_SLOTS];

   // radix register, kept clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrd_pkg::RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= itrd_pkg::clamp_radix(csr_wr_data);
      end
   end

   // restoring division, one quotient bit per cycle
   assign trial  = {rem_ff, q_ff[VALUE_BITS-1]};
   assign ge     = (trial >= {1'b0, radix_ff});
   assign rem_in = ge ? DW'(trial - {1'b0, radix_ff}) : DW'(trial);
   assign q_in   = {q_ff[VALUE_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= '0;
         rem_ff <= '0;
      end else if (cmd.load) begin
         q_ff   <= req_value;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= q_in;
         rem_ff <= cmd.div_last ? '0 : rem_in;
      end
   end

   // digit count and emit index; digits beyond the slots are dropped
   assign store_en = cmd.div_last && (n_ff < CNT_W'(DIGIT_SLOTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         idx_ff <= '0;
      end else if (cmd.load) begin
         n_ff <= '0;
      end else if (store_en) begin
         n_ff   <= n_ff + 1'b1;
         idx_ff <= n_ff[AW-1:0];
      end else if (cmd.next_digit) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // digit store, least significant first
   always_ff @(posedge clock) begin
      if (store_en) digit_mem[n_ff[AW-1:0]] <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_data_ff <= digit_mem[idx_ff];
   end

   // status and result payload
   assign stat.q_next_zero = (q_in == '0);
   assign stat.idx_zero    = (idx_ff == '0);
   assign rsp_digit_char   = itrd_pkg::digit_to_ascii(rd_data_ff);
   assign rsp_last         = (idx_ff == '0);

endmodule

`default_nettype wire

@@ hdl/integer_to_radix_digits.sv @@
// Converts one unsigned integer per req transaction into ASCII digits in the
// radix held in the csr register (written clamped to 2..36, reset 10), and
// returns one rsp transaction per digit, most significant first: '0'-'9' then
// 'A'-'Z', with last set on the final digit; zero gives a single '0'. One
// integer is in flight at a time: req_ch.ready is high only while idle. A
// restoring divider produces one quotient bit per cycle until every digit is
// divided; the digits are then emitted, each by a digit store read and then
// an output step that holds until rsp_ch.ready is high. Write the radix only
// while idle.
`default_nettype none

module integer_to_radix_digits #(
   parameter int DIGIT_SLOTS = itrd_pkg::DIGIT_SLOTS_DEF,
   parameter int VALUE_BITS  = itrd_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [itrd_pkg::RADIX_W-1:0] csr_wr_data,
   itrd_req_if.sink                          req_ch,
   itrd_rsp_if.source                        rsp_ch
);

   itrd_pkg::cmd_type    cmd;
   itrd_pkg::status_type stat;

   // sequencing
   itrd_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // divider, digit store and result payload
   itrd_dp #(
      .DIGIT_SLOTS (DIGIT_SLOTS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_value      (VALUE_BITS'(req_ch.value)),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_digit_char (rsp_ch.digit_char),
      .rsp_last       (rsp_ch.last)
   );

endmodule

`default_nettype wire

@@ hdl/itrd_check.sv @@
`default_nettype none

module itrd_check (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [itrd_pkg::CHAR_W-1:0] rsp_digit_char,
   input wire logic                        rsp_last
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   // one integer at a time: no new input while digits are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while digits pending");

   // an accepted integer needs division cycles before any digit
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("digit appeared without division");

   // the final digit returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not idle after final digit");

   // every digit is a legal character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
         (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd90))
      else $error("digit character out of range");

endmodule

bind integer_to_radix_digits itrd_check u_itrd_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_digit_char (rsp_ch.digit_char),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire
